FILE: src/swa_pkg.sv
`default_nettype none
package swa_pkg;

  // Field and register widths.
  localparam int DIM_W      = 10;
  localparam int CFG_DIM_W  = 11;
  localparam int RATE_W     = 16;
  localparam int Q_W        = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Image size limits and register reset values.
  localparam logic [CFG_DIM_W-1:0] MIN_DIM   = 11'd2;
  localparam logic [CFG_DIM_W-1:0] MAX_DIM   = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 11'd512;
  localparam logic [RATE_W-1:0]    RATE_RESET = 16'd0;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd2;

  // 2^32 / (2*pi), rounded, and the quarter-wave sine polynomial.
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;

  // Divider and square root: stages and steps per stage.
  localparam int NORM_STG = 4;
  localparam int NORM_BPS = 4;
  localparam int SQRT_STG = 4;
  localparam int SQRT_BPS = 4;

  // Pipeline depth, and the stage whose coordinate feeds the rotation.
  localparam int LAT     = 20;
  localparam int ROT_SRC = 17;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
  } coord_t;

endpackage
`default_nettype wire

FILE: src/swa_in_if.sv
`default_nettype none
interface swa_in_if import swa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] dest_x;
  logic [DIM_W-1:0] dest_y;

  modport source (output valid, dest_x, dest_y, input ready);
  modport sink   (input valid, dest_x, dest_y, output ready);
endinterface
`default_nettype wire

FILE: src/swa_out_if.sv
`default_nettype none
interface swa_out_if import swa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] source_x;
  logic [DIM_W-1:0] source_y;
  logic             outside;

  modport source (output valid, source_x, source_y, outside, input ready);
  modport sink   (input valid, source_x, source_y, outside, output ready);
endinterface
`default_nettype wire

FILE: src/swa_norm.sv
`default_nettype none
module swa_norm import swa_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [DIM_W-1:0]        pos,
  input  wire logic [DIM_W-1:0]        dim_m1,
  output logic signed [Q_W-1:0]        norm
);

  logic [DIM_W-1:0] rem_r [0:NORM_STG];
  logic [Q_W-1:0]   quo_r [0:NORM_STG];
  logic             ovf_r [0:NORM_STG];
  logic [DIM_W-1:0] rem_nxt [1:NORM_STG];
  logic [Q_W-1:0]   quo_nxt [1:NORM_STG];
  logic [DIM_W-1:0] rem_t;
  logic [Q_W-1:0]   quo_t;
  logic [DIM_W:0]   sh;

  // Restoring division of pos * 2^16 by dim_m1, a few quotient bits per stage.
  always_comb begin
    rem_t = '0;
    quo_t = '0;
    sh    = '0;
    for (int k = 1; k <= NORM_STG; k++) begin
      rem_t = rem_r[k-1];
      quo_t = quo_r[k-1];
      for (int b = 0; b < NORM_BPS; b++) begin
        sh = {rem_t, 1'b0};
        if (sh >= {1'b0, dim_m1}) begin
          rem_t = DIM_W'(sh - {1'b0, dim_m1});
          quo_t = {quo_t[Q_W-2:0], 1'b1};
        end else begin
          rem_t = sh[DIM_W-1:0];
          quo_t = {quo_t[Q_W-2:0], 1'b0};
        end
      end
      rem_nxt[k] = rem_t;
      quo_nxt[k] = quo_t;
    end
  end

  // The quotient reaches 2^16 exactly when pos is at least dim_m1.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= (pos >= dim_m1);
      rem_r[0] <= (pos >= dim_m1) ? '0 : pos;
      quo_r[0] <= '0;
      for (int k = 1; k <= NORM_STG; k++) begin
        ovf_r[k] <= ovf_r[k-1];
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  // Subtracting one half flips the top bit; overflow saturates.
  assign norm = ovf_r[NORM_STG] ? 16'sh7FFF
                                : $signed({~quo_r[NORM_STG][Q_W-1], quo_r[NORM_STG][Q_W-2:0]});

endmodule
`default_nettype wire

FILE: src/swa_sqrt.sv
`default_nettype none
module swa_sqrt import swa_pkg::*; (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [31:0]   sq_a,
  input  wire logic [31:0]   sq_b,
  output logic [Q_W-1:0]     root
);

  logic [31:0] v_r   [0:SQRT_STG];
  logic [31:0] res_r [0:SQRT_STG];
  logic [31:0] v_nxt   [1:SQRT_STG];
  logic [31:0] res_nxt [1:SQRT_STG];
  logic [31:0] v_t;
  logic [31:0] res_t;
  logic [31:0] bit_t;

  // Digit-by-digit square root, a few result bits per stage.
  always_comb begin
    v_t   = '0;
    res_t = '0;
    bit_t = '0;
    for (int k = 1; k <= SQRT_STG; k++) begin
      v_t   = v_r[k-1];
      res_t = res_r[k-1];
      for (int b = 0; b < SQRT_BPS; b++) begin
        bit_t = 32'd1 << (30 - 2 * ((k - 1) * SQRT_BPS + b));
        if (v_t >= res_t + bit_t) begin
          v_t   = v_t - (res_t + bit_t);
          res_t = (res_t >> 1) + bit_t;
        end else begin
          res_t = res_t >> 1;
        end
      end
      v_nxt[k]   = v_t;
      res_nxt[k] = res_t;
    end
  end

  // The first stage adds the two squares.
  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]   <= sq_a + sq_b;
      res_r[0] <= '0;
      for (int k = 1; k <= SQRT_STG; k++) begin
        v_r[k]   <= v_nxt[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign root = res_r[SQRT_STG][Q_W-1:0];

endmodule
`default_nettype wire

FILE: src/swa_sin.sv
`default_nettype none
module swa_sin import swa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [15:0]       phase,
  output logic signed [Q_W-1:0]  sine
);

  logic [15:0] z1_r, z2a_r, z2b_r;
  logic [15:0] zz1_r, zz2_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [14:0] t1_r;
  logic [15:0] t2_r;
  logic signed [Q_W-1:0] sine_r;

  logic [14:0] u_fold;
  logic [15:0] z_nxt;
  logic [31:0] zz_prod;
  logic [27:0] c_prod;
  logic [30:0] b_prod;
  logic [31:0] a_prod;
  logic [14:0] mag;

  // Fold the phase into the first quarter wave.
  always_comb begin
    u_fold  = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    z_nxt   = {u_fold, 1'b0};
    zz_prod = z_nxt * z_nxt;
    c_prod  = {16'b0, SIN_C} * {12'b0, zz1_r};
    b_prod  = {16'b0, t1_r} * {15'b0, zz2_r};
    a_prod  = t2_r * z2b_r;
    mag     = (a_prod[31:15] > 17'd32767) ? 15'h7FFF : a_prod[29:15];
  end

  // Polynomial in z squared, one multiply per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      z1_r   <= z_nxt;
      zz1_r  <= zz_prod[30:15];
      neg1_r <= phase[15];

      t1_r   <= SIN_B - {2'b0, c_prod[27:15]};
      zz2_r  <= zz1_r;
      z2a_r  <= z1_r;
      neg2_r <= neg1_r;

      t2_r   <= SIN_A - b_prod[30:15];
      z2b_r  <= z2a_r;
      neg3_r <= neg2_r;

      sine_r <= neg3_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign sine = sine_r;

endmodule
`default_nettype wire

FILE: src/swirl_warp_source_address_top.sv
// Swirl source address generator: one destination coordinate in, one source address out.
// Throughput is one request per cycle while results are taken, set by the fully pipelined
// divider, square root and sine units.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads width 512, height 512
// and swirl rate 0.
`default_nettype none
module swirl_warp_source_address_top import swa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  swa_in_if.sink                      in_chan,
  swa_out_if.source                   out_chan,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DIM_W-1:0] width_r, height_r;
  logic [RATE_W-1:0]    rate_r;
  logic [CFG_DIM_W-1:0] w_cl, h_cl;
  logic [DIM_W-1:0]     w_m1, h_m1, cx, cy;

  logic       vld_r [0:LAT-1];
  coord_t     xy_r  [0:ROT_SRC];
  logic       adv;

  logic signed [Q_W-1:0] nx, ny;
  logic signed [31:0]    nxx_r, nyy_r;
  logic [Q_W-1:0]        root;
  logic [32:0]           ang_r;
  logic [46:0]           ph_h_r;
  logic [45:0]           ph_l_r;
  logic [63:0]           ph_sum;
  logic [15:0]           phase_r;
  logic signed [Q_W-1:0] sin_v, cos_v;

  logic signed [11:0]    dx, dy;
  logic signed [27:0]    p_cx_r, p_sy_r, p_sx_r, p_cy_r;
  logic signed [29:0]    vx, vy;
  logic signed [14:0]    sx, sy;
  logic                  off;
  logic [DIM_W-1:0]      src_x_r, src_y_r;
  logic                  outside_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      rate_r   <= RATE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[CFG_DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[CFG_DIM_W-1:0];
        REG_RATE:   rate_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Sizes are clamped to the supported range wherever they are used.
  always_comb begin
    w_cl = (width_r < MIN_DIM) ? MIN_DIM : ((width_r > MAX_DIM) ? MAX_DIM : width_r);
    h_cl = (height_r < MIN_DIM) ? MIN_DIM : ((height_r > MAX_DIM) ? MAX_DIM : height_r);
    w_m1 = DIM_W'(w_cl - 11'd1);
    h_m1 = DIM_W'(h_cl - 11'd1);
    cx   = w_cl[CFG_DIM_W-1:1];
    cy   = h_cl[CFG_DIM_W-1:1];
  end

  // The whole pipeline advances unless a finished result is waiting.
  assign adv           = !vld_r[LAT-1] || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_chan.valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Destination coordinate travels alongside until the rotation.
  always_ff @(posedge clk) begin
    if (adv) begin
      xy_r[0] <= '{x: in_chan.dest_x, y: in_chan.dest_y};
      for (int k = 1; k <= ROT_SRC; k++) xy_r[k] <= xy_r[k-1];
    end
  end

  // Normalize to Q1.15.
  swa_norm u_norm_x (.clk(clk), .en(adv), .pos(in_chan.dest_x), .dim_m1(w_m1), .norm(nx));
  swa_norm u_norm_y (.clk(clk), .en(adv), .pos(in_chan.dest_y), .dim_m1(h_m1), .norm(ny));

  // Squares of the normalized coordinates.
  always_ff @(posedge clk) begin
    if (adv) begin
      nxx_r <= nx * nx;
      nyy_r <= ny * ny;
    end
  end

  swa_sqrt u_sqrt (.clk(clk), .en(adv), .sq_a(nxx_r), .sq_b(nyy_r), .root(root));

  // Angle, then turns: the product with 1/(2*pi) is split in two halves.
  assign ph_sum = {1'b0, ph_h_r, 16'b0} + {18'b0, ph_l_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r   <= {17'b0, rate_r} * {16'b0, 17'(17'h10000 - {1'b0, root})};
      ph_h_r  <= {30'b0, ang_r[32:16]} * {17'b0, INV_TWO_PI};
      ph_l_r  <= {30'b0, ang_r[15:0]} * {16'b0, INV_TWO_PI};
      phase_r <= ph_sum[54:39];
    end
  end

  swa_sin u_sin (.clk(clk), .en(adv), .phase(phase_r), .sine(sin_v));
  swa_sin u_cos (.clk(clk), .en(adv), .phase(16'(phase_r + 16'd16384)), .sine(cos_v));

  // Rotation products about the integer center.
  assign dx = $signed({2'b0, xy_r[ROT_SRC].x}) - $signed({2'b0, cx});
  assign dy = $signed({2'b0, xy_r[ROT_SRC].y}) - $signed({2'b0, cy});

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cx_r <= cos_v * dx;
      p_sy_r <= sin_v * dy;
      p_sx_r <= sin_v * dx;
      p_cy_r <= cos_v * dy;
    end
  end

  // Sum, truncate toward zero and test against the image.
  always_comb begin
    vx  = 30'(p_cx_r) + 30'(p_sy_r) + $signed({5'b0, cx, 15'b0});
    vy  = 30'(p_cy_r) - 30'(p_sx_r) + $signed({5'b0, cy, 15'b0});
    sx  = vx[29] ? 15'((vx + 30'sd32767) >>> 15) : 15'(vx >>> 15);
    sy  = vy[29] ? 15'((vy + 30'sd32767) >>> 15) : 15'(vy >>> 15);
    off = sx[14] || sy[14] || (sx > $signed({5'b0, w_m1})) || (sy > $signed({5'b0, h_m1}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outside_r <= off;
      src_x_r   <= off ? '0 : sx[DIM_W-1:0];
      src_y_r   <= off ? '0 : sy[DIM_W-1:0];
    end
  end

  assign out_chan.valid    = vld_r[LAT-1];
  assign out_chan.source_x = src_x_r;
  assign out_chan.source_y = src_y_r;
  assign out_chan.outside  = outside_r;

`ifndef SYNTH
  a_out_empty_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_chan.valid)
    else $error("result valid right after reset");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.outside |-> out_chan.source_x == '0 && out_chan.source_y == '0)
    else $error("outside result with nonzero address");

  a_inside_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.outside |-> out_chan.source_x <= w_m1 && out_chan.source_y <= h_m1)
    else $error("inside result beyond the image");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> vld_r[LAT-2] == $past(vld_r[LAT-2]))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

FILE: sim/swa_addr_checker.sv
`timescale 1ns / 1ps
module swa_addr_checker import swa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  swa_in_if                          in_mon,
  swa_out_if                         out_mon,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         addr_pending
);

  typedef struct packed {
    logic [DIM_W-1:0] src_x;
    logic [DIM_W-1:0] src_y;
    logic             off;
  } src_addr_t;

  // Shadow copy of the configuration registers.
  logic [CFG_DIM_W-1:0] cur_width;
  logic [CFG_DIM_W-1:0] cur_height;
  logic [RATE_W-1:0]    cur_rate;

  src_addr_t addr_queue[$];

  function automatic int unsigned clamp_size(logic [CFG_DIM_W-1:0] d);
    if (d < MIN_DIM) return MIN_DIM;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  // Coordinate scaled to Q1.15, saturated at the top.
  function automatic longint norm_q15(int unsigned pos, int unsigned dim);
    int unsigned q;
    longint v;
    q = (pos * 32'd65536) / (dim - 1);
    v = longint'(q) - 32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic int unsigned root32(int unsigned v);
    int unsigned res;
    int unsigned b;
    res = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Quarter-wave polynomial; all arithmetic wraps at 32 bits.
  function automatic int unsigned quarter_wave(int unsigned u);
    int unsigned z;
    int unsigned z2;
    int unsigned t;
    z  = u * 2;
    z2 = (z * z) >> 15;
    t  = (int'(SIN_C) * z2) >> 15;
    t  = int'(SIN_B) - t;
    t  = (t * z2) >> 15;
    t  = int'(SIN_A) - t;
    t  = (t * z) >> 15;
    if (t > 32767) t = 32767;
    return t;
  endfunction

  function automatic longint sine_q15(int unsigned ph);
    int unsigned quad;
    int unsigned u;
    longint s;
    quad = (ph >> 14) & 3;
    u = ph & 16'h3FFF;
    s = (quad & 1) ? quarter_wave(16384 - u) : quarter_wave(u);
    return (quad & 2) ? -s : s;
  endfunction

  function automatic longint trunc_q15(longint v);
    if (v >= 0) return v >>> 15;
    return -((-v) >>> 15);
  endfunction

  // Source address of one destination pixel under the current settings.
  function automatic src_addr_t swirl_source(logic [DIM_W-1:0] px, logic [DIM_W-1:0] py);
    int unsigned w;
    int unsigned h;
    longint nx;
    longint ny;
    longint sq;
    int unsigned r;
    longint unsigned ang;
    int unsigned ph;
    longint s;
    longint c;
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint sx;
    longint sy;
    src_addr_t res;
    w  = clamp_size(cur_width);
    h  = clamp_size(cur_height);
    nx = norm_q15(px, w);
    ny = norm_q15(py, h);
    sq = nx * nx + ny * ny;
    r  = root32(sq[31:0]);
    ang = longint'(cur_rate) * longint'(65536 - r);
    ph = ((ang * 64'd683565276) >> 39) & 64'hFFFF;
    s  = sine_q15(ph);
    c  = sine_q15((ph + 16384) & 32'hFFFF);
    cx = w / 2;
    cy = h / 2;
    dx = longint'(px) - cx;
    dy = longint'(py) - cy;
    sx = trunc_q15(c * dx + s * dy + cx * 32768);
    sy = trunc_q15(-s * dx + c * dy + cy * 32768);
    if (sx < 0 || sx > w - 1 || sy < 0 || sy > h - 1) begin
      res = '{src_x: '0, src_y: '0, off: 1'b1};
    end else begin
      res = '{src_x: sx[DIM_W-1:0], src_y: sy[DIM_W-1:0], off: 1'b0};
    end
    return res;
  endfunction

  // Track register writes, predict each request and compare each result.
  always @(posedge clk) begin
    src_addr_t want;
    if (!rst_n) begin
      cur_width  <= DIM_RESET;
      cur_height <= DIM_RESET;
      cur_rate   <= RATE_RESET;
      addr_queue.delete();
      mismatches   <= 0;
      addr_pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WIDTH: begin
            cur_width <= cfg_data[CFG_DIM_W-1:0];
          end
          REG_HEIGHT: begin
            cur_height <= cfg_data[CFG_DIM_W-1:0];
          end
          REG_RATE: begin
            cur_rate <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (addr_queue.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d outside=%0b", $time,
                   out_mon.source_x, out_mon.source_y, out_mon.outside);
          mismatches <= mismatches + 1;
        end else begin
          want = addr_queue.pop_front();
          if (out_mon.source_x !== want.src_x || out_mon.source_y !== want.src_y ||
              out_mon.outside !== want.off) begin
            $display("%0t: expected x=%0d y=%0d outside=%0b, got x=%0d y=%0d outside=%0b",
                     $time, want.src_x, want.src_y, want.off,
                     out_mon.source_x, out_mon.source_y, out_mon.outside);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        addr_queue.push_back(swirl_source(in_mon.dest_x, in_mon.dest_y));
      end
      addr_pending <= addr_queue.size();
    end
  end

endmodule

FILE: sim/swirl_warp_source_address_top_tb.sv
`timescale 1ns / 1ps
module swirl_warp_source_address_top_tb;
  import swa_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    addr_pending;

  swa_in_if  in_chan ();
  swa_out_if out_chan ();

  // Traffic shaping, in percent, and the long receiver hold-off.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_cnt;
  int cur_w;
  int cur_h;

  swirl_warp_source_address_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  swa_addr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .addr_pending (addr_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off on request.
  initial begin
    out_chan.ready = 1'b0;
    hold_seen = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

  // Send one request, idling first at the current rate; entered at a falling edge.
  task automatic send_request(int px, int py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.dest_x <= px[DIM_W-1:0];
    in_chan.dest_y <= py[DIM_W-1:0];
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Pause until every result is back and the pipeline has emptied.
  task automatic drain;
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (addr_pending != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size_rate(int w, int h, int rate);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RATE, rate);
    cur_w = (w & 11'h7FF) < 2 ? 2 : ((w & 11'h7FF) > 1024 ? 1024 : (w & 11'h7FF));
    cur_h = (h & 11'h7FF) < 2 ? 2 : ((h & 11'h7FF) > 1024 ? 1024 : (h & 11'h7FF));
  endtask

  function automatic int pick_coord(int dim);
    if ($urandom_range(99) < 85) return $urandom_range(dim - 1);
    return $urandom_range(1023);
  endfunction

  task automatic random_requests(int n);
    for (int i = 0; i < n; i++) begin
      send_request(pick_coord(cur_w), pick_coord(cur_h));
    end
  endtask

  task automatic set_traffic(int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.dest_x = '0;
    in_chan.dest_y = '0;
    hold_req = 0;
    cur_w = 512;
    cur_h = 512;
    set_traffic(0, 0);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners under reset settings: no swirl.
    send_request(0, 0);
    send_request(511, 511);
    send_request(256, 256);
    send_request(1023, 1023);
    send_request(1023, 0);
    send_request(0, 1023);
    send_request(600, 100);

    // Strong swirl, including points off the image to the right and below.
    set_size_rate(640, 480, 16'hFFFF);
    send_request(0, 0);
    send_request(639, 479);
    send_request(320, 240);
    send_request(1023, 1023);
    send_request(700, 10);
    send_request(10, 500);

    // Sizes below and above range saturate to 2 and 1024.
    set_size_rate(0, 1, 256);
    send_request(0, 0);
    send_request(1, 1);
    send_request(1023, 512);
    set_size_rate(2047, 1025, 1);
    send_request(0, 0);
    send_request(1023, 1023);
    send_request(512, 512);
    send_request(341, 700);

    // Random phases across settings and traffic patterns.
    set_size_rate(1024, 1024, 400);
    set_traffic(0, 0);
    random_requests(150);
    set_size_rate(2, 1024, 65535);
    set_traffic(72, 0);
    random_requests(150);
    set_size_rate(1024, 2, 300);
    set_traffic(0, 72);
    random_requests(150);
    set_size_rate(100, 60, 1000);
    set_traffic(6, 6);
    random_requests(150);

    // Long receiver hold-off while requests keep coming.
    set_size_rate(320, 240, 128);
    set_traffic(0, 0);
    hold_req++;
    random_requests(150);
    drain();
    random_requests(60);

    for (int p = 0; p < 4; p++) begin
      set_size_rate($urandom_range(2, 1024), $urandom_range(2, 1024), $urandom_range(65535));
      case (p)
        0: set_traffic(0, 0);
        1: set_traffic(72, 0);
        2: set_traffic(0, 72);
        default: set_traffic(6, 6);
      endcase
      random_requests(150);
    end

    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (addr_pending != 0) @(negedge clk);
    repeat (LAT + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
